FILE: sv/srt_pkg.sv
// shared types, constants and helpers for the sogi three-phase rms tracker
package srt_pkg;

  localparam int unsigned DEFAULT_PHASES = 3;
  localparam logic [31:0] TWO_PI_TS_RESET = 32'd2698565;
  localparam logic [32:0] INV_SQRT2_Q32 = 33'd3037000500;
  localparam logic [16:0] RMS_MAX = 17'd32767;
  localparam logic [16:0] FREQ_MIN = 17'd20;
  localparam logic [16:0] FREQ_SUBST = 17'd200;
  localparam logic [34:0] GAIN_DIVISOR = 35'd100;
  localparam int unsigned MUL_W = 33;
  localparam int unsigned DIV_STEPS = 64;
  localparam int unsigned SQRT_STEPS = 32;

  typedef enum logic [3:0] {
    S_IDLE,
    S_GMUL,
    S_GDIV,
    S_KDIV,
    S_ESTEP,
    S_EMUL,
    S_YMUL,
    S_SQY,
    S_SQQ,
    S_SQRT,
    S_K2MUL,
    S_K1MUL,
    S_RMS,
    S_DONE
  } seq_state_t;

  // clamp a 34 bit signed value to signed 32 bit
  function automatic logic [31:0] sat32(input logic signed [33:0] v);
    logic [31:0] res;
    res = v[31:0];
    if (v > 34'sd2147483647) begin
      res = 32'h7fff_ffff;
    end else if (v < -34'sd2147483648) begin
      res = 32'h8000_0000;
    end
    return res;
  endfunction

  // magnitude of a signed 32 bit value, unsigned
  function automatic logic [31:0] mag32(input logic [31:0] v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

endpackage

FILE: sv/sogi_three_phase_rms_tracker.sv
// sogi based per-phase amplitude tracker with lowpass smoothing and rms output
//
// channels: input transactions (three current samples, signed frequency, run)
// on in_valid/in_ready; one result transaction (three rms values) per input on
// out_valid/out_ready; the gain register two_pi_ts is written through
// cfg_valid/cfg_ready, always ready, and must only change while idle.
// all arithmetic runs on shared bit-serial units: a 33x33 shift-add
// multiplier, a restoring divider and a two-bits-per-step square root.
// per item: one multiply and two divides for the loop gain and lowpass
// coefficients, then per phase six multiplies, one square root and the rms
// scaling multiply; most of an item's processing time is spent in the
// multiplier. in_ready is high only while the sequencer is idle, at the
// earliest in the same cycle as out_valid rises, so no new transaction is
// taken while one is still in progress.
// the result sits in an output register, so a new input is accepted while
// the previous result still waits; if the receiver stalls longer than one
// item's processing, the sequencer holds in its final step until the output
// register frees up.
// reset (rst, synchronous) clears all sogi and smoothing state, loads the default gain
module sogi_three_phase_rms_tracker #(
  parameter int unsigned PHASES = srt_pkg::DEFAULT_PHASES
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] two_pi_ts,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic signed [15:0] phase_a_current,
  input  logic signed [15:0] phase_b_current,
  input  logic signed [15:0] phase_c_current,
  input  logic signed [16:0] out_frequency,
  input  logic        run,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [14:0] phase_a_rms,
  output logic [14:0] phase_b_rms,
  output logic [14:0] phase_c_rms
);

  import srt_pkg::*;

  localparam int unsigned PW = (PHASES > 1) ? $clog2(PHASES) : 1;

  seq_state_t state, state_next;

  logic [31:0] gain_cfg;

  // per-phase state
  logic [31:0] sogi_direct [PHASES];
  logic [31:0] sogi_quad [PHASES];
  logic [31:0] amp_smooth [PHASES];

  // latched transaction
  logic signed [15:0] smp [3];
  logic               run_r;
  logic [PW-1:0]      ph;

  // per-item working registers
  logic [31:0] g;
  logic [31:0] k1;
  logic [32:0] k2;
  logic [31:0] y_w;
  logic [31:0] yq_w;
  logic        e_neg;
  logic [63:0] sumsq;
  logic [31:0] amp;
  logic [63:0] acc;
  logic [14:0] rms_work [3];

  // multiplier
  logic [MUL_W-1:0]   mul_a, mul_b;
  logic [2*MUL_W-1:0] mul_acc;
  logic [5:0]         mul_cnt;
  logic               mul_busy;
  logic               mul_go;
  logic [MUL_W-1:0]   mul_a_in, mul_b_in;

  // divider
  logic [63:0] div_dvd, div_quot;
  logic [34:0] div_rem, div_dvs;
  logic [6:0]  div_cnt;
  logic        div_busy;
  logic        div_go;
  logic [63:0] div_dvd_in;
  logic [34:0] div_dvs_in;
  logic [35:0] div_trial;

  // square root
  logic [63:0] sq_n, sq_r, sq_b, sq_try;
  logic [5:0]  sq_cnt;
  logic        sq_busy;
  logic        sq_go;
  logic [63:0] sq_n_in;
  logic [4:0]  sq_bidx;

  // combinational datapath values
  logic [16:0]        f_mag, f_sel;
  logic [31:0]        g_clamp;
  logic signed [15:0] x_smp;
  logic [31:0]        y_cur, yq_cur, e_val;
  logic signed [33:0] e_full;
  logic [63:0]        prod_signed;
  logic [31:0]        prod_hi;
  logic [31:0]        y_new, yq_new, as_new;
  logic [63:0]        acc_sum;
  logic [64:0]        rms_sum;
  logic [16:0]        rms_raw;
  logic [14:0]        rms_val;
  logic               last_ph;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);

  assign mul_busy = (mul_cnt != 6'd0);
  assign div_busy = (div_cnt != 7'd0);
  assign sq_busy  = (sq_cnt != 6'd0);

  // frequency magnitude with the low-speed substitute
  assign f_mag = out_frequency[16] ? 17'(~out_frequency + 17'd1) : 17'(out_frequency);
  assign f_sel = (f_mag < FREQ_MIN) ? FREQ_SUBST : f_mag;

  assign g_clamp = (div_quot[63:32] != 32'd0) ? 32'hffff_ffff : div_quot[31:0];

  always_comb begin
    x_smp = '0;
    for (int k = 0; k < 3; k++) begin
      if (int'(ph) == k) begin
        x_smp = smp[k];
      end
    end
  end

  assign y_cur  = run_r ? sogi_direct[ph] : 32'd0;
  assign yq_cur = run_r ? sogi_quad[ph] : 32'd0;
  assign e_full = ((run_r ? 34'(x_smp) : 34'sd0) <<< 16) - 34'(signed'(y_cur))
                  - 34'(signed'(yq_cur));
  assign e_val  = sat32(e_full);

  // sign-restored product, floor of the division by 2^32
  always_comb begin
    logic neg;
    neg = (state == S_EMUL) ? e_neg : y_w[31];
    prod_signed = neg ? (~mul_acc[63:0] + 64'd1) : mul_acc[63:0];
  end
  assign prod_hi = prod_signed[63:32];
  assign y_new   = sat32(34'(signed'(y_w)) + 34'(signed'(prod_hi)));
  assign yq_new  = sat32(34'(signed'(yq_w)) + 34'(signed'(prod_hi)));

  assign acc_sum = acc + mul_acc[63:0];
  assign as_new  = acc_sum[63:32];

  assign rms_sum = {1'b0, mul_acc[63:0]} + 65'h0_8000_0000_0000;
  assign rms_raw = rms_sum[64:48];
  assign rms_val = (rms_raw > RMS_MAX) ? 15'(RMS_MAX) : rms_raw[14:0];

  assign last_ph = (int'(ph) == PHASES - 1);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    mul_go     = 1'b0;
    mul_a_in   = '0;
    mul_b_in   = '0;
    div_go     = 1'b0;
    div_dvd_in = '0;
    div_dvs_in = '0;
    sq_go      = 1'b0;
    sq_n_in    = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_GMUL;
          mul_go     = 1'b1;
          mul_a_in   = {1'b0, gain_cfg};
          mul_b_in   = MUL_W'(f_sel);
        end
      end
      S_GMUL: begin
        if (!mul_busy) begin
          state_next = S_GDIV;
          div_go     = 1'b1;
          div_dvd_in = mul_acc[63:0];
          div_dvs_in = GAIN_DIVISOR;
        end
      end
      S_GDIV: begin
        if (!div_busy) begin
          state_next = S_KDIV;
          div_go     = 1'b1;
          div_dvd_in = {g_clamp, 32'd0};
          div_dvs_in = {3'b100, g_clamp};
        end
      end
      S_KDIV: begin
        if (!div_busy) begin
          state_next = S_ESTEP;
        end
      end
      S_ESTEP: begin
        state_next = S_EMUL;
        mul_go     = 1'b1;
        mul_a_in   = {1'b0, mag32(e_val)};
        mul_b_in   = {1'b0, g};
      end
      S_EMUL: begin
        if (!mul_busy) begin
          state_next = S_YMUL;
          mul_go     = 1'b1;
          mul_a_in   = {1'b0, mag32(y_new)};
          mul_b_in   = {1'b0, g};
        end
      end
      S_YMUL: begin
        if (!mul_busy) begin
          state_next = S_SQY;
          mul_go     = 1'b1;
          mul_a_in   = {1'b0, mag32(y_w)};
          mul_b_in   = {1'b0, mag32(y_w)};
        end
      end
      S_SQY: begin
        if (!mul_busy) begin
          state_next = S_SQQ;
          mul_go     = 1'b1;
          mul_a_in   = {1'b0, mag32(yq_w)};
          mul_b_in   = {1'b0, mag32(yq_w)};
        end
      end
      S_SQQ: begin
        if (!mul_busy) begin
          state_next = S_SQRT;
          sq_go      = 1'b1;
          sq_n_in    = sumsq + mul_acc[63:0];
        end
      end
      S_SQRT: begin
        if (!sq_busy) begin
          state_next = S_K2MUL;
          mul_go     = 1'b1;
          mul_a_in   = k2;
          mul_b_in   = {1'b0, amp_smooth[ph]};
        end
      end
      S_K2MUL: begin
        if (!mul_busy) begin
          state_next = S_K1MUL;
          mul_go     = 1'b1;
          mul_a_in   = {1'b0, k1};
          mul_b_in   = {1'b0, amp};
        end
      end
      S_K1MUL: begin
        if (!mul_busy) begin
          state_next = S_RMS;
          mul_go     = 1'b1;
          mul_a_in   = {1'b0, as_new};
          mul_b_in   = INV_SQRT2_Q32;
        end
      end
      S_RMS: begin
        if (!mul_busy) begin
          state_next = last_ph ? S_DONE : S_ESTEP;
        end
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      gain_cfg <= TWO_PI_TS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      gain_cfg <= two_pi_ts;
    end
  end

  // control: unit counters, phase index, output valid, per-phase state
  always_ff @(posedge clk) begin
    if (rst) begin
      mul_cnt   <= '0;
      div_cnt   <= '0;
      sq_cnt    <= '0;
      ph        <= '0;
      out_valid <= 1'b0;
      for (int k = 0; k < PHASES; k++) begin
        sogi_direct[k] <= '0;
        sogi_quad[k]   <= '0;
        amp_smooth[k]  <= '0;
      end
    end else begin
      if (mul_go) begin
        mul_cnt <= 6'(MUL_W);
      end else if (mul_busy) begin
        mul_cnt <= mul_cnt - 6'd1;
      end
      if (div_go) begin
        div_cnt <= 7'(DIV_STEPS);
      end else if (div_busy) begin
        div_cnt <= div_cnt - 7'd1;
      end
      if (sq_go) begin
        sq_cnt <= 6'(SQRT_STEPS);
      end else if (sq_busy) begin
        sq_cnt <= sq_cnt - 6'd1;
      end
      if (state == S_KDIV) begin
        ph <= '0;
      end else if (state == S_RMS && !mul_busy && !last_ph) begin
        ph <= ph + 1'b1;
      end
      if (state == S_EMUL && !mul_busy) begin
        sogi_direct[ph] <= y_new;
      end
      if (state == S_YMUL && !mul_busy) begin
        sogi_quad[ph] <= yq_new;
      end
      if (state == S_K1MUL && !mul_busy) begin
        amp_smooth[ph] <= as_new;
      end
      if (state == S_DONE && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      smp[0] <= phase_a_current;
      smp[1] <= phase_b_current;
      smp[2] <= phase_c_current;
      run_r  <= run;
      for (int k = 0; k < 3; k++) begin
        rms_work[k] <= '0;
      end
    end
    if (state == S_GDIV && !div_busy) begin
      g <= g_clamp;
    end
    if (state == S_KDIV && !div_busy) begin
      k1 <= div_quot[31:0];
      k2 <= 33'h1_0000_0000 - {1'b0, div_quot[31:0]};
    end
    if (state == S_ESTEP) begin
      y_w   <= y_cur;
      yq_w  <= yq_cur;
      e_neg <= e_val[31];
    end
    if (state == S_EMUL && !mul_busy) begin
      y_w <= y_new;
    end
    if (state == S_YMUL && !mul_busy) begin
      yq_w <= yq_new;
    end
    if (state == S_SQQ && !mul_busy) begin
      sumsq <= sumsq;
    end
    if (state == S_SQY && !mul_busy) begin
      sumsq <= mul_acc[63:0];
    end
    if (state == S_SQRT && !sq_busy) begin
      amp <= sq_r[31:0];
    end
    if (state == S_K2MUL && !mul_busy) begin
      acc <= mul_acc[63:0];
    end
    if (state == S_RMS && !mul_busy) begin
      for (int k = 0; k < 3; k++) begin
        if (int'(ph) == k) begin
          rms_work[k] <= rms_val;
        end
      end
    end
    if (state == S_DONE && (!out_valid || out_ready)) begin
      phase_a_rms <= rms_work[0];
      phase_b_rms <= rms_work[1];
      phase_c_rms <= rms_work[2];
    end
  end

  // shift-add multiplier, multiplier bits msb first
  always_ff @(posedge clk) begin
    if (mul_go) begin
      mul_a   <= mul_a_in;
      mul_b   <= mul_b_in;
      mul_acc <= '0;
    end else if (mul_busy) begin
      mul_acc <= {mul_acc[2*MUL_W-2:0], 1'b0}
                 + (mul_b[MUL_W-1] ? {{MUL_W{1'b0}}, mul_a} : '0);
      mul_b   <= {mul_b[MUL_W-2:0], 1'b0};
    end
  end

  // restoring divider, one quotient bit a cycle
  assign div_trial = {div_rem, div_dvd[63]};

  always_ff @(posedge clk) begin
    if (div_go) begin
      div_dvd  <= div_dvd_in;
      div_dvs  <= div_dvs_in;
      div_rem  <= '0;
      div_quot <= '0;
    end else if (div_busy) begin
      div_dvd <= {div_dvd[62:0], 1'b0};
      if (div_trial >= {1'b0, div_dvs}) begin
        div_rem  <= 35'(div_trial - {1'b0, div_dvs});
        div_quot <= {div_quot[62:0], 1'b1};
      end else begin
        div_rem  <= div_trial[34:0];
        div_quot <= {div_quot[62:0], 1'b0};
      end
    end
  end

  // square root, two radicand bits a cycle
  assign sq_bidx = 5'(sq_cnt - 6'd1);
  assign sq_b    = 64'd1 << {sq_bidx, 1'b0};
  assign sq_try  = sq_r + sq_b;

  always_ff @(posedge clk) begin
    if (sq_go) begin
      sq_n <= sq_n_in;
      sq_r <= '0;
    end else if (sq_busy) begin
      if (sq_n >= sq_try) begin
        sq_n <= sq_n - sq_try;
        sq_r <= (sq_r >> 1) + sq_b;
      end else begin
        sq_r <= sq_r >> 1;
      end
    end
  end

  // the shared units never overlap
  assert property (@(posedge clk) disable iff (rst)
    $onehot0({mul_busy, div_busy, sq_busy}))
    else $error("arithmetic units busy at the same time");

  // no unit still running when a new transaction may enter
  assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !(mul_busy || div_busy || sq_busy))
    else $error("ready while a unit is busy");

  // leaving the final step always presents a result
  assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && (!out_valid || out_ready)) |=> out_valid)
    else $error("result not presented after final step");

  // the square root start strobe only fires from the sequencer's issue point
  assert property (@(posedge clk) disable iff (rst)
    sq_go |-> (state == S_SQQ && !mul_busy))
    else $error("square root started out of sequence");

endmodule

FILE: tb/testbench.sv
// self-checking testbench for the sogi three-phase rms tracker
module testbench;
  import srt_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 200000;
  localparam int unsigned DRAIN_CYCLES = 2000;
  localparam int unsigned N_RANDOM = 1030;

  typedef struct packed {
    logic signed [15:0] cur_a;
    logic signed [15:0] cur_b;
    logic signed [15:0] cur_c;
    logic signed [16:0] freq;
    logic               run_flag;
  } sample_t;

  typedef struct packed {
    logic [14:0] rms_a;
    logic [14:0] rms_b;
    logic [14:0] rms_c;
  } rms_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [31:0] two_pi_ts = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [15:0] phase_a_current = '0;
  logic signed [15:0] phase_b_current = '0;
  logic signed [15:0] phase_c_current = '0;
  logic signed [16:0] out_frequency = '0;
  logic run = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [14:0] phase_a_rms, phase_b_rms, phase_c_rms;

  sogi_three_phase_rms_tracker DUT (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .two_pi_ts(two_pi_ts),
    .in_valid(in_valid), .in_ready(in_ready),
    .phase_a_current(phase_a_current), .phase_b_current(phase_b_current),
    .phase_c_current(phase_c_current), .out_frequency(out_frequency), .run(run),
    .out_valid(out_valid), .out_ready(out_ready),
    .phase_a_rms(phase_a_rms), .phase_b_rms(phase_b_rms), .phase_c_rms(phase_c_rms)
  );

  // predictor state: gain register and per-phase sogi / lowpass state
  logic [31:0] gain_reg;
  logic signed [31:0] direct_st [3];
  logic signed [31:0] quad_st [3];
  logic [31:0] smooth_st [3];

  sample_t pending_samples[$];
  rms_t expected_rms[$];
  logic [31:0] pending_gain = '0;
  bit gain_write_req = 1'b0;

  int unsigned sender_idle_pct = 0;
  int unsigned receiver_stall_pct = 0;
  bit hold_sender = 1'b0;
  bit failed = 1'b0;
  int unsigned quiet_cycles = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  // saturate a wide signed value to signed 32 bit
  function automatic logic signed [31:0] clamp32(input logic signed [95:0] v);
    if (v > 96'sd2147483647) return 32'sh7fff_ffff;
    if (v < -96'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic logic [31:0] int_sqrt(input logic [63:0] n);
    logic [63:0] root, bitv, rem;
    rem = n;
    root = '0;
    bitv = 64'd1 << 62;
    while (bitv > rem) bitv >>= 2;
    while (bitv != 0) begin
      if (rem >= root + bitv) begin
        rem = rem - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv >>= 2;
    end
    return root[31:0];
  endfunction

  // advance the predictor by one sample and return the rms triple
  function automatic rms_t track_sample(input sample_t s);
    logic [16:0] fmag;
    logic [63:0] gain_full, k1, k2, amp, acc;
    logic [127:0] num, den;
    logic signed [95:0] x, err, y, yq, prod;
    logic [63:0] sq, r;
    logic signed [15:0] cur [3];
    logic [14:0] res [3];
    rms_t out;
    cur[0] = s.cur_a;
    cur[1] = s.cur_b;
    cur[2] = s.cur_c;
    fmag = s.freq[16] ? (~s.freq + 17'd1) : s.freq;
    if (fmag < 17'd20) fmag = 17'd200;
    gain_full = (64'(gain_reg) * 64'(fmag)) / 64'd100;
    if (gain_full > 64'hffff_ffff) gain_full = 64'hffff_ffff;
    num = 128'(gain_full) << 32;
    den = (128'd4 << 32) + 128'(gain_full);
    k1 = 64'(num / den);
    k2 = (64'd1 << 32) - k1;
    for (int p = 0; p < 3; p++) begin
      x = s.run_flag ? 96'(cur[p]) * 96'sd65536 : 96'sd0;
      if (!s.run_flag) begin
        direct_st[p] = '0;
        quad_st[p] = '0;
      end
      err = 96'(clamp32(x - 96'(direct_st[p]) - 96'(quad_st[p])));
      prod = err * $signed({32'd0, gain_full});
      y = 96'(clamp32(96'(direct_st[p]) + (prod >>> 32)));
      prod = y * $signed({32'd0, gain_full});
      yq = 96'(clamp32(96'(quad_st[p]) + (prod >>> 32)));
      direct_st[p] = y[31:0];
      quad_st[p] = yq[31:0];
      sq = 64'(y * y) + 64'(yq * yq);
      amp = 64'(int_sqrt(sq));
      acc = k2 * 64'(smooth_st[p]) + k1 * amp;
      smooth_st[p] = acc[63:32];
      r = (64'(smooth_st[p]) * 64'd3037000500 + (64'd1 << 47)) >> 48;
      res[p] = (r > 64'd32767) ? 15'h7fff : r[14:0];
    end
    out.rms_a = res[0];
    out.rms_b = res[1];
    out.rms_c = res[2];
    return out;
  endfunction

  function automatic sample_t rand_sample();
    sample_t s;
    int unsigned pick;
    s.cur_a = 16'($urandom);
    s.cur_b = 16'($urandom);
    s.cur_c = 16'($urandom);
    pick = $urandom_range(0, 9);
    // mostly mains-like frequencies, sometimes extremes and raw patterns
    if (pick < 6) s.freq = 17'($urandom_range(0, 10000));
    else if (pick < 8) s.freq = -$signed(17'($urandom_range(0, 50000)));
    else s.freq = 17'($urandom);
    if (pick == 3) s.freq = 17'($urandom_range(0, 25));
    s.run_flag = ($urandom_range(0, 19) != 0);
    return s;
  endfunction

  function automatic sample_t mk(input int a, input int b, input int c, input int f,
                                 input bit r);
    sample_t s;
    s.cur_a = 16'(a);
    s.cur_b = 16'(b);
    s.cur_c = 16'(c);
    s.freq = 17'(f);
    s.run_flag = r;
    return s;
  endfunction

  // driver: presents pending samples and the gain write, idles at random
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        cfg_valid <= 1'b0;
      end else if (gain_write_req && !cfg_valid) begin
        cfg_valid <= 1'b1;
        two_pi_ts <= pending_gain;
      end
      if (in_valid && in_ready) begin
        expected_rms.push_back(track_sample(pending_samples.pop_front()));
      end
      if (!(in_valid && !in_ready)) begin
        // choose next presentation only when no transaction is held
        if (pending_samples.size() > (in_valid && in_ready ? 0 : 0) && !hold_sender &&
            !gain_write_req && $urandom_range(0, 99) >= sender_idle_pct) begin
          in_valid <= 1'b1;
          phase_a_current <= pending_samples[0].cur_a;
          phase_b_current <= pending_samples[0].cur_b;
          phase_c_current <= pending_samples[0].cur_c;
          out_frequency <= pending_samples[0].freq;
          run <= pending_samples[0].run_flag;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: random back-pressure and result checking
  always @(posedge clk) begin
    rms_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_rms.size() == 0) begin
          $error("rms result with no expectation pending");
          failed = 1'b1;
        end else begin
          want = expected_rms.pop_front();
          if (phase_a_rms !== want.rms_a) begin
            $error("phase_a_rms expected %0d actual %0d", want.rms_a, phase_a_rms);
            failed = 1'b1;
          end
          if (phase_b_rms !== want.rms_b) begin
            $error("phase_b_rms expected %0d actual %0d", want.rms_b, phase_b_rms);
            failed = 1'b1;
          end
          if (phase_c_rms !== want.rms_c) begin
            $error("phase_c_rms expected %0d actual %0d", want.rms_c, phase_c_rms);
            failed = 1'b1;
          end
        end
      end
      out_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("testbench NOT OK");
        $finish;
      end
    end
  end

  task automatic wait_drained();
    while (pending_samples.size() != 0 || in_valid || expected_rms.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // gain register write while the block is idle; predictor follows
  task automatic write_gain(input logic [31:0] g);
    wait_drained();
    pending_gain = g;
    gain_write_req = 1'b1;
    @(posedge clk);
    while (!(cfg_valid && cfg_ready)) @(posedge clk);
    gain_write_req = 1'b0;
    gain_reg = g;
    @(posedge clk);
  endtask

  task automatic run_random(input int unsigned n, input int unsigned idle,
                            input int unsigned stall);
    sender_idle_pct = idle;
    receiver_stall_pct = stall;
    for (int i = 0; i < n; i++) pending_samples.push_back(rand_sample());
    wait_drained();
  endtask

  initial begin
    gain_reg = TWO_PI_TS_RESET;
    for (int p = 0; p < 3; p++) begin
      direct_st[p] = '0;
      quad_st[p] = '0;
      smooth_st[p] = '0;
    end
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed: field extremes, stopped, low and most negative frequency
    pending_samples.push_back(mk(32767, -32768, 0, 5000, 1'b1));
    pending_samples.push_back(mk(-32768, 32767, -1, -5000, 1'b1));
    pending_samples.push_back(mk(32767, 32767, 32767, 50000, 1'b1));
    pending_samples.push_back(mk(-32768, -32768, -32768, -50000, 1'b1));
    pending_samples.push_back(mk(1000, -2000, 3000, 0, 1'b1));
    pending_samples.push_back(mk(1000, -2000, 3000, 19, 1'b1));
    pending_samples.push_back(mk(1000, -2000, 3000, -19, 1'b1));
    pending_samples.push_back(mk(1000, -2000, 3000, 20, 1'b1));
    pending_samples.push_back(mk(1000, -2000, 3000, -65536, 1'b1));
    pending_samples.push_back(mk(1000, -2000, 3000, 65535, 1'b1));
    pending_samples.push_back(mk(12345, 2222, -7777, 5000, 1'b0));
    pending_samples.push_back(mk(0, 0, 0, 5000, 1'b0));
    wait_drained();

    // gain extremes: the maximum gain drives the integrators into saturation, then zero gain
    write_gain(32'hffff_ffff);
    for (int i = 0; i < 6; i++)
      pending_samples.push_back(mk(32767, -32768, 32767, 50000, 1'b1));
    pending_samples.push_back(mk(-32768, 32767, -32768, -50000, 1'b1));
    wait_drained();
    write_gain(32'd0);
    pending_samples.push_back(mk(32767, -32768, 1, 5000, 1'b1));
    pending_samples.push_back(mk(-5, 5, 0, 5000, 1'b0));
    wait_drained();

    write_gain(TWO_PI_TS_RESET);
    run_random(N_RANDOM / 5, 0, 0);
    run_random(N_RANDOM / 5, 73, 0);

    // sender holds off until all results are back
    hold_sender = 1'b1;
    for (int i = 0; i < 5; i++) pending_samples.push_back(rand_sample());
    while (expected_rms.size() != 0) @(posedge clk);
    hold_sender = 1'b0;

    write_gain($urandom);
    run_random(N_RANDOM / 5, 0, 73);
    write_gain(32'd27000000);
    run_random(N_RANDOM / 5, 34, 34);
    write_gain(TWO_PI_TS_RESET);
    run_random(N_RANDOM / 5, 0, 0);

    if (!failed && expected_rms.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end
endmodule

FILE: sogi_three_phase_rms_tracker.f
sv/srt_pkg.sv
sv/sogi_three_phase_rms_tracker.sv
tb/testbench.sv
